// ===== rtl/cps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_pkg
// Types and constants shared by the process scheduler and its checker.
// ----------------------------------------------------------------------------
package cps_pkg;

    localparam int TIME_W  = 21;
    localparam int ID_W    = 8;
    localparam int ARR_W   = 16;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int POL_W   = 3;
    localparam int QNT_W   = 8;
    localparam int CFG_W   = 8;

    // Scheduling policy codes.
    localparam logic [POL_W-1:0] POL_FCFS  = 3'd0;
    localparam logic [POL_W-1:0] POL_SJF   = 3'd1;
    localparam logic [POL_W-1:0] POL_SRTF  = 3'd2;
    localparam logic [POL_W-1:0] POL_PRIO  = 3'd3;
    localparam logic [POL_W-1:0] POL_PPRIO = 3'd4;
    localparam logic [POL_W-1:0] POL_RR    = 3'd5;

    // Item operation codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes.
    localparam logic REG_POLICY  = 1'b0;
    localparam logic REG_QUANTUM = 1'b1;

    // One entry of the process table.
    typedef struct packed {
        logic [ID_W-1:0]    pid;
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [BURST_W-1:0] remaining;
        logic [PRIO_W-1:0]  prio;
    } t_slot;

    // Sequencer states, one-hot.
    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_LOAD   = 10'b0000000010,
        S_CRD    = 10'b0000000100,
        S_CCHK   = 10'b0000001000,
        S_SCAN   = 10'b0000010000,
        S_RRPOST = 10'b0000100000,
        S_PRD    = 10'b0001000000,
        S_PWAIT  = 10'b0010000000,
        S_PCHK   = 10'b0100000000,
        S_RUN    = 10'b1000000000
    } t_state;

endpackage

// ===== rtl/cpu_process_scheduler_unit.sv =====
`timescale 1ns / 1ps
// A load item goes straight to its result; a tick item reads the current
// process and, unless a non-preemptive policy keeps it, scans the table
// (once more per newly queued process under round robin), then under round
// robin checks the slice and pops the queue. The serial scan sets the pace.
// One item is worked at a time; a result waits in the output register.
// Reset (synchronous, active low) empties the table and queue at once.
// ----------------------------------------------------------------------------
// cpu_process_scheduler_unit
// Tick-driven process scheduler: the process table and the round robin
// queue sit in single-port-read memories; the table is scanned one entry a cycle.
// ----------------------------------------------------------------------------
module cpu_process_scheduler_unit #(
    parameter int MAX_PROCS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [cps_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_opcode,
    input  logic [cps_pkg::ID_W-1:0]    i_proc_id,
    input  logic [cps_pkg::ARR_W-1:0]   i_proc_arrival,
    input  logic [cps_pkg::BURST_W-1:0] i_proc_burst,
    input  logic [cps_pkg::PRIO_W-1:0]  i_proc_priority,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [cps_pkg::ID_W-1:0]    o_run_id,
    output logic                        o_idle,
    output logic                        o_finished,
    output logic [cps_pkg::TIME_W-1:0]  o_completion_time,
    output logic [cps_pkg::TIME_W-1:0]  o_turnaround,
    output logic [cps_pkg::TIME_W-1:0]  o_waiting,
    output logic                        o_table_full
);
    import cps_pkg::*;

    localparam int SW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam logic [SW:0] MAXC = (SW+1)'(MAX_PROCS);
    localparam logic [SW-1:0] LASTI = SW'(MAX_PROCS - 1);

    // Storage
    t_slot         slot_mem [MAX_PROCS];
    logic [SW-1:0] fifo_mem [MAX_PROCS];
    t_slot         r_rdata;
    logic [SW-1:0] r_fdata;

    // Control state
    t_state            r_state;
    logic [POL_W-1:0]  r_policy;
    logic [QNT_W-1:0]  r_quantum;
    logic [SW:0]       r_count;
    logic [TIME_W-1:0] r_now;
    logic [SW-1:0]     r_cur;
    logic              r_cur_valid;
    logic [QNT_W-1:0]  r_slice;
    logic [SW-1:0]     r_head;
    logic [SW:0]       r_fill;
    // Number of queue entries that hold each slot.
    logic [SW:0]       r_inq [MAX_PROCS];
    t_slot             r_rec;
    logic [SW-1:0]     r_pslot;

    // Scan state
    logic [SW:0]   r_sidx;
    logic          r_dv;
    logic [SW-1:0] r_didx;
    logic          r_bfound;
    logic [SW-1:0] r_bslot;
    logic [31:0]   r_bkey;
    t_slot         r_best;

    // Captured load item
    t_slot r_ld;

    // Output register
    logic              r_ovalid;
    logic [ID_W-1:0]   r_orun;
    logic              r_oidle;
    logic              r_ofin;
    logic [TIME_W-1:0] r_ocomp;
    logic [TIME_W-1:0] r_ota;
    logic [TIME_W-1:0] r_owait;
    logic              r_ofull;

    // Decoded configuration
    logic [POL_W-1:0] pol;
    logic [QNT_W-1:0] qnt;
    logic             is_rr;
    logic             nonpre;
    always_comb begin
        pol    = (r_policy > POL_RR) ? POL_FCFS : r_policy;
        qnt    = (r_quantum == '0) ? QNT_W'(1) : r_quantum;
        is_rr  = (pol == POL_RR);
        nonpre = (pol == POL_FCFS) || (pol == POL_SJF) || (pol == POL_PRIO);
    end

    // Eligibility of the entry just read
    function automatic logic elig(input logic [SW-1:0] s, input t_slot d,
                                  input logic [SW:0] cnt, input logic [TIME_W-1:0] now);
        elig = ({1'b0, s} < cnt) && ({5'd0, d.arrival} <= now) && (d.remaining != '0);
    endfunction

    // Queue tail position
    logic [SW:0]   tail_sum;
    logic [SW-1:0] tail;
    logic [SW-1:0] head_inc;
    logic          q_full;
    always_comb begin
        tail_sum = {1'b0, r_head} + r_fill;
        tail     = (tail_sum >= MAXC) ? SW'(tail_sum - MAXC) : tail_sum[SW-1:0];
        head_inc = (r_head == LASTI) ? '0 : r_head + SW'(1);
        q_full   = (r_fill == MAXC);
    end

    // Scan key and candidate test
    logic [31:0] cand_key;
    logic        cand_ok;
    always_comb begin
        case (pol)
            POL_SJF:   cand_key = {r_rdata.burst, r_rdata.arrival};
            POL_SRTF:  cand_key = {r_rdata.remaining, r_rdata.arrival};
            POL_PRIO, POL_PPRIO:
                       cand_key = {8'd0, r_rdata.prio, r_rdata.arrival};
            default:   cand_key = {r_rdata.arrival, r_rdata.arrival};
        endcase
        cand_ok = r_dv && elig(r_didx, r_rdata, r_count, r_now);
        if (is_rr && ((r_cur_valid && r_cur == r_didx) || (r_inq[r_didx] != '0)))
            cand_ok = 1'b0;
    end

    logic scan_done;
    assign scan_done = (r_sidx == MAXC) && !r_dv;

    // Output register free to take a result
    logic out_free;
    assign out_free = !r_ovalid || i_out_ready;

    // A result is written into the output register this cycle
    logic res_fire;
    assign res_fire = ((r_state == S_LOAD) || (r_state == S_RUN)) && out_free;

    // Read address of the table memory
    logic [SW-1:0] rd_addr;
    always_comb begin
        case (r_state)
            S_SCAN:  rd_addr = r_sidx[SW-1:0];
            S_PWAIT: rd_addr = r_fdata;
            default: rd_addr = r_cur;
        endcase
    end

    // Table memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= slot_mem[rd_addr];
        if (r_state == S_LOAD && out_free && r_count < MAXC) begin
            slot_mem[r_count[SW-1:0]] <= r_ld;
        end else if (r_state == S_RUN && out_free && r_cur_valid) begin
            slot_mem[r_cur] <= '{pid: r_rec.pid, arrival: r_rec.arrival,
                                 burst: r_rec.burst,
                                 remaining: r_rec.remaining - BURST_W'(1),
                                 prio: r_rec.prio};
        end
    end

    // Queue memory pushes; a push into a full queue is dropped.
    logic          push_en;
    logic [SW-1:0] push_slot;
    always_comb begin
        push_en   = 1'b0;
        push_slot = r_bslot;
        if (r_state == S_SCAN && scan_done && is_rr && r_bfound && !q_full) begin
            push_en = 1'b1;
        end else if (r_state == S_RRPOST && r_cur_valid && r_slice >= qnt && !q_full) begin
            push_en   = 1'b1;
            push_slot = r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fdata <= fifo_mem[r_head];
        if (push_en) begin
            fifo_mem[tail] <= push_slot;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy  <= POL_FCFS;
            r_quantum <= QNT_W'(2);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_POLICY:  r_policy  <= i_cfg_data[POL_W-1:0];
                REG_QUANTUM: r_quantum <= i_cfg_data[QNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Result values of a run tick
    logic [TIME_W-1:0]  done_t;
    logic [TIME_W-1:0]  ta;
    logic [BURST_W-1:0] rem_n;
    always_comb begin
        done_t = r_now + TIME_W'(1);
        ta     = done_t - TIME_W'(r_rec.arrival);
        rem_n  = r_rec.remaining - BURST_W'(1);
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_now       <= '0;
            r_cur       <= '0;
            r_cur_valid <= 1'b0;
            r_slice     <= '0;
            r_head      <= '0;
            r_fill      <= '0;
            for (int k = 0; k < MAX_PROCS; k++) begin
                r_inq[k] <= '0;
            end
            r_sidx      <= '0;
            r_dv        <= 1'b0;
            r_bfound    <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (res_fire) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (push_en) begin
                r_fill           <= r_fill + (SW+1)'(1);
                r_inq[push_slot] <= r_inq[push_slot] + (SW+1)'(1);
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_ld <= '{pid: i_proc_id, arrival: i_proc_arrival,
                                  burst: i_proc_burst, remaining: i_proc_burst,
                                  prio: i_proc_priority};
                        r_state <= (i_opcode == OP_LOAD) ? S_LOAD : S_CRD;
                    end
                end
                S_LOAD: begin
                    if (out_free) begin
                        r_orun   <= '0;
                        r_oidle  <= 1'b1;
                        r_ofin   <= 1'b0;
                        r_ocomp  <= '0;
                        r_ota    <= '0;
                        r_owait  <= '0;
                        r_ofull  <= (r_count >= MAXC);
                        if (r_count < MAXC) begin
                            r_count <= r_count + (SW+1)'(1);
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_CRD: begin
                    r_state <= S_CCHK;
                end
                // Drop a current process that can no longer run, then run it or scan
                S_CCHK: begin
                    r_rec    <= r_rdata;
                    r_sidx   <= '0;
                    r_dv     <= 1'b0;
                    r_bfound <= 1'b0;
                    if (r_cur_valid && !elig(r_cur, r_rdata, r_count, r_now)) begin
                        r_cur_valid <= 1'b0;
                        r_state     <= S_SCAN;
                    end else if (!is_rr && r_cur_valid && nonpre) begin
                        r_state <= S_RUN;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                // Serial minimum search over the table
                S_SCAN: begin
                    if (r_sidx != MAXC) begin
                        r_sidx <= r_sidx + (SW+1)'(1);
                        r_dv   <= 1'b1;
                        r_didx <= r_sidx[SW-1:0];
                    end else begin
                        r_dv <= 1'b0;
                    end
                    if (cand_ok && (!r_bfound || cand_key < r_bkey)) begin
                        r_bfound <= 1'b1;
                        r_bslot  <= r_didx;
                        r_bkey   <= cand_key;
                        r_best   <= r_rdata;
                    end
                    if (scan_done) begin
                        if (is_rr) begin
                            r_sidx   <= '0;
                            r_bfound <= 1'b0;
                            // A full queue takes no more arrivals this tick.
                            if (!r_bfound || q_full) begin
                                r_state <= S_RRPOST;
                            end
                        end else begin
                            if (r_bfound) begin
                                if (!r_cur_valid || r_cur != r_bslot) begin
                                    r_slice <= '0;
                                end
                                r_cur       <= r_bslot;
                                r_cur_valid <= 1'b1;
                                r_rec       <= r_best;
                            end else begin
                                r_cur_valid <= 1'b0;
                            end
                            r_state <= S_RUN;
                        end
                    end
                end
                // Slice expiry, then decide whether to pop the queue
                S_RRPOST: begin
                    if (r_cur_valid && r_slice >= qnt) begin
                        r_cur_valid <= 1'b0;
                        r_state     <= S_PRD;
                    end else if (!r_cur_valid && r_fill != '0) begin
                        r_state <= S_PRD;
                    end else begin
                        r_state <= S_RUN;
                    end
                end
                S_PRD: begin
                    r_head  <= head_inc;
                    r_fill  <= r_fill - (SW+1)'(1);
                    r_state <= S_PWAIT;
                end
                S_PWAIT: begin
                    r_pslot         <= r_fdata;
                    r_inq[r_fdata]  <= r_inq[r_fdata] - (SW+1)'(1);
                    r_state         <= S_PCHK;
                end
                S_PCHK: begin
                    if (elig(r_pslot, r_rdata, r_count, r_now)) begin
                        r_cur       <= r_pslot;
                        r_cur_valid <= 1'b1;
                        r_slice     <= '0;
                        r_rec       <= r_rdata;
                        r_state     <= S_RUN;
                    end else if (r_fill != '0) begin
                        r_state <= S_PRD;
                    end else begin
                        r_state <= S_RUN;
                    end
                end
                // Run one time unit and report
                S_RUN: begin
                    if (out_free) begin
                        r_ofull  <= 1'b0;
                        if (r_cur_valid) begin
                            r_orun  <= r_rec.pid;
                            r_oidle <= 1'b0;
                            if (rem_n == '0) begin
                                r_ofin      <= 1'b1;
                                r_ocomp     <= done_t;
                                r_ota       <= ta;
                                r_owait     <= ta - TIME_W'(r_rec.burst);
                                r_cur_valid <= 1'b0;
                                r_slice     <= '0;
                            end else begin
                                r_ofin  <= 1'b0;
                                r_ocomp <= '0;
                                r_ota   <= '0;
                                r_owait <= '0;
                                if (r_slice != '1) begin
                                    r_slice <= r_slice + QNT_W'(1);
                                end
                            end
                        end else begin
                            r_orun  <= '0;
                            r_oidle <= 1'b1;
                            r_ofin  <= 1'b0;
                            r_ocomp <= '0;
                            r_ota   <= '0;
                            r_owait <= '0;
                        end
                        r_now   <= done_t;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_out_valid       = r_ovalid;
    assign o_run_id          = r_orun;
    assign o_idle            = r_oidle;
    assign o_finished        = r_ofin;
    assign o_completion_time = r_ocomp;
    assign o_turnaround      = r_ota;
    assign o_waiting         = r_owait;
    assign o_table_full      = r_ofull;

endmodule

// ===== rtl/cps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cps_checker
// Port-level checks on the results of the process scheduler.
// ----------------------------------------------------------------------------
module cps_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [cps_pkg::ID_W-1:0]   o_run_id,
    input logic                       o_idle,
    input logic                       o_finished,
    input logic [cps_pkg::TIME_W-1:0] o_completion_time,
    input logic                       o_table_full
);
    import cps_pkg::*;

    // A finished process cannot come with an idle result.
    a_fin_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_finished |-> !o_idle)
        else $error("finished result marked idle");

    // A refused load is an idle result with nothing finished.
    a_full_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_table_full |-> o_idle && !o_finished)
        else $error("table full result not idle");

    // Idle results carry no process id.
    a_idle_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_idle |-> o_run_id == '0)
        else $error("idle result with a process id");

    // Completion time is only reported with a finished process.
    a_comp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_finished |-> o_completion_time == '0)
        else $error("completion time without finish");

    // A waiting result holds until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_run_id))
        else $error("result dropped before taken");

endmodule

bind cpu_process_scheduler_unit cps_checker u_cps_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_run_id          (o_run_id),
    .o_idle            (o_idle),
    .o_finished        (o_finished),
    .o_completion_time (o_completion_time),
    .o_table_full      (o_table_full)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tick-driven process scheduler. A driver sends
// load and tick items from a queue and a monitor compares every result, field
// by field, with the output of a built-in scheduling predictor. The run walks
// through every policy and several quantum settings, mostly under random idling.
// ----------------------------------------------------------------------------
module tb_top;
    import cps_pkg::*;

    localparam int NPROC     = 16;
    localparam int WDOG_MAX  = 20000;
    localparam int SETTLE    = 80;

    typedef struct {
        logic               op;
        logic [ID_W-1:0]    id;
        logic [ARR_W-1:0]   arr;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } t_job;

    typedef struct {
        logic [ID_W-1:0]   run_id;
        logic              idle;
        logic              finished;
        logic [TIME_W-1:0] ct;
        logic [TIME_W-1:0] ta;
        logic [TIME_W-1:0] wt;
        logic              full;
    } t_sched_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = REG_POLICY;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_opcode = OP_TICK;
    logic [ID_W-1:0] i_proc_id = '0;
    logic [ARR_W-1:0] i_proc_arrival = '0;
    logic [BURST_W-1:0] i_proc_burst = '0;
    logic [PRIO_W-1:0] i_proc_priority = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [ID_W-1:0] o_run_id;
    logic o_idle, o_finished, o_table_full;
    logic [TIME_W-1:0] o_completion_time, o_turnaround, o_waiting;

    cpu_process_scheduler_unit #(.MAX_PROCS(NPROC)) dut (.*);

    always #1 i_clk = ~i_clk;

    t_job       job_q[$];
    t_sched_res sched_exp_q[$];
    int         snd_idle = 0;
    int         rcv_idle = 0;
    int         n_err = 0;
    int         quiet_cycles = 0;

    // Shadow copy of the scheduler state.
    logic [2:0]         m_policy = POL_FCFS;
    logic [7:0]         m_quantum = 8'd2;
    logic [ID_W-1:0]    t_pid[NPROC];
    logic [ARR_W-1:0]   t_arr[NPROC];
    logic [BURST_W-1:0] t_burst[NPROC];
    logic [BURST_W-1:0] t_rem[NPROC];
    logic [PRIO_W-1:0]  t_prio[NPROC];
    bit                 t_used[NPROC];
    int                 n_loaded = 0;
    logic [TIME_W-1:0]  now_t = '0;
    int                 cur_slot = 0;
    bit                 cur_valid = 0;
    int                 slice_cnt = 0;
    int                 rr_q[NPROC];
    int                 rr_head = 0;
    int                 rr_fill = 0;

    function automatic bit can_run(int s);
        return t_used[s] && ({5'd0, t_arr[s]} <= now_t) && t_rem[s] != 0;
    endfunction

    function automatic bit queued(int s);
        for (int k = 0; k < rr_fill; k++)
            if (rr_q[(rr_head + k) % NPROC] == s) return 1;
        return 0;
    endfunction

    function automatic void enqueue(int s);
        if (rr_fill < NPROC) begin
            rr_q[(rr_head + rr_fill) % NPROC] = s;
            rr_fill++;
        end
    endfunction

    // Best eligible slot by policy key, arrival breaking ties; NPROC if none.
    function automatic int best_slot(logic [2:0] pol, bit fresh_only);
        int best;
        logic [31:0] bk, k;
        logic [15:0] prim;
        best = NPROC;
        bk = '0;
        for (int s = 0; s < NPROC; s++) begin
            if (!can_run(s)) continue;
            if (fresh_only && ((cur_valid && cur_slot == s) || queued(s))) continue;
            case (pol)
                POL_SJF:              prim = t_burst[s];
                POL_SRTF:             prim = t_rem[s];
                POL_PRIO, POL_PPRIO:  prim = {8'd0, t_prio[s]};
                default:              prim = t_arr[s];
            endcase
            k = {prim, t_arr[s]};
            if (best == NPROC || k < bk) begin
                best = s;
                bk = k;
            end
        end
        return best;
    endfunction

    function automatic t_sched_res sched_predict(t_job j);
        t_sched_res r;
        logic [2:0] pol;
        int q, run, s;
        logic [TIME_W-1:0] done_t, tat;
        r = '{default: '0};
        pol = (m_policy > POL_RR) ? POL_FCFS : m_policy;
        q = (m_quantum == 0) ? 1 : m_quantum;
        run = NPROC;
        if (j.op == OP_LOAD) begin
            r.idle = 1;
            if (n_loaded >= NPROC) begin
                r.full = 1;
                return r;
            end
            t_pid[n_loaded] = j.id;
            t_arr[n_loaded] = j.arr;
            t_burst[n_loaded] = j.burst;
            t_rem[n_loaded] = j.burst;
            t_prio[n_loaded] = j.prio;
            t_used[n_loaded] = 1;
            n_loaded++;
            return r;
        end
        if (cur_valid && !can_run(cur_slot)) cur_valid = 0;
        if (pol == POL_RR) begin
            // New arrivals join the queue ahead of a process whose slice ran out.
            for (int n = 0; n < NPROC; n++) begin
                s = best_slot(POL_FCFS, 1);
                if (s >= NPROC) break;
                enqueue(s);
            end
            if (cur_valid && slice_cnt >= q) begin
                enqueue(cur_slot);
                cur_valid = 0;
            end
            while (!cur_valid && rr_fill > 0) begin
                s = rr_q[rr_head];
                rr_head = (rr_head + 1) % NPROC;
                rr_fill--;
                if (can_run(s)) begin
                    cur_slot = s;
                    cur_valid = 1;
                    slice_cnt = 0;
                end
            end
            if (cur_valid) run = cur_slot;
        end else if (cur_valid && (pol == POL_FCFS || pol == POL_SJF || pol == POL_PRIO)) begin
            run = cur_slot;
        end else begin
            run = best_slot(pol, 0);
            if (run < NPROC) begin
                if (!cur_valid || cur_slot != run) slice_cnt = 0;
                cur_slot = run;
                cur_valid = 1;
            end else begin
                cur_valid = 0;
            end
        end
        if (run >= NPROC) begin
            r.idle = 1;
        end else begin
            done_t = now_t + 1'b1;
            tat = done_t - {5'd0, t_arr[run]};
            r.run_id = t_pid[run];
            t_rem[run] = t_rem[run] - 1'b1;
            if (slice_cnt < 255) slice_cnt++;
            if (t_rem[run] == 0) begin
                r.finished = 1;
                r.ct = done_t;
                r.ta = tat;
                r.wt = tat - {5'd0, t_burst[run]};
                cur_valid = 0;
                slice_cnt = 0;
            end
        end
        now_t = now_t + 1'b1;
        return r;
    endfunction

    // Driver: presents queued items and predicts each one as it is accepted.
    always @(posedge i_clk) begin
        t_job j;
        bit took;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            took = i_in_valid && o_in_ready;
            if (took) begin
                j = '{i_opcode, i_proc_id, i_proc_arrival, i_proc_burst, i_proc_priority};
                sched_exp_q.push_back(sched_predict(j));
            end
            if (!i_in_valid || took) begin
                if (job_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
                    j = job_q.pop_front();
                    i_opcode <= j.op;
                    i_proc_id <= j.id;
                    i_proc_arrival <= j.arr;
                    i_proc_burst <= j.burst;
                    i_proc_priority <= j.prio;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= ($urandom_range(99) >= rcv_idle);
    end

    // Monitor: each result against the oldest expectation.
    always @(posedge i_clk) begin
        t_sched_res e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (sched_exp_q.size() == 0) begin
                $error("result with no expectation waiting");
                n_err++;
            end else begin
                e = sched_exp_q.pop_front();
                if (o_run_id !== e.run_id) begin
                    $error("run_id: expected %0d, got %0d", e.run_id, o_run_id);
                    n_err++;
                end
                if (o_idle !== e.idle) begin
                    $error("idle: expected %0d, got %0d", e.idle, o_idle);
                    n_err++;
                end
                if (o_finished !== e.finished) begin
                    $error("finished: expected %0d, got %0d", e.finished, o_finished);
                    n_err++;
                end
                if (o_completion_time !== e.ct) begin
                    $error("completion_time: expected %0d, got %0d", e.ct,
                           o_completion_time);
                    n_err++;
                end
                if (o_turnaround !== e.ta) begin
                    $error("turnaround: expected %0d, got %0d", e.ta, o_turnaround);
                    n_err++;
                end
                if (o_waiting !== e.wt) begin
                    $error("waiting: expected %0d, got %0d", e.wt, o_waiting);
                    n_err++;
                end
                if (o_table_full !== e.full) begin
                    $error("table_full: expected %0d, got %0d", e.full, o_table_full);
                    n_err++;
                end
            end
        end
    end

    // Watchdog on cycles in which no item moves on either side.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WDOG_MAX) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic cfg_write(logic idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        if (idx == REG_POLICY) m_policy = data[2:0];
        else m_quantum = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold off until every item has been sent and every result has arrived.
    task automatic drain();
        while (job_q.size() > 0 || i_in_valid || sched_exp_q.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic add_load(logic [ID_W-1:0] id, logic [ARR_W-1:0] arr,
                            logic [BURST_W-1:0] b, logic [PRIO_W-1:0] p);
        job_q.push_back('{OP_LOAD, id, arr, b, p});
    endtask

    task automatic add_tick();
        job_q.push_back('{OP_TICK, ID_W'($urandom), ARR_W'($urandom),
                          BURST_W'($urandom), PRIO_W'($urandom)});
    endtask

    initial begin
        logic [2:0] pols[11];
        logic [7:0] qnts[11];
        pols = '{POL_FCFS, POL_SJF, POL_SRTF, POL_PRIO, POL_PPRIO, POL_RR,
                 POL_RR, POL_RR, 3'd6, 3'd7, POL_RR};
        qnts = '{8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd1, 8'd255, 8'd0, 8'd2, 8'd2, 8'd3};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        snd_idle = 33;
        rcv_idle = 70;

        // Directed: field extremes, a zero burst, equal arrivals, then a full table.
        add_load(8'd0, 16'd0, 16'd3, 8'd255);
        add_load(8'd255, 16'd0, 16'd2, 8'd0);
        add_load(8'd7, 16'd65535, 16'd5, 8'd1);
        add_load(8'd9, 16'd1, 16'd0, 8'd3);
        add_load(8'd11, 16'd900, 16'd65535, 8'd128);
        add_load(8'd12, 16'd2, 16'd4, 8'd4);
        add_load(8'd13, 16'd2, 16'd4, 8'd4);
        for (int i = 0; i < 9; i++)
            add_load(ID_W'($urandom), ARR_W'($urandom_range(400)),
                     BURST_W'($urandom_range(120, 1)), PRIO_W'($urandom));
        add_load(8'hAA, 16'hFFFF, 16'hFFFF, 8'hFF);
        repeat (8) add_tick();
        drain();

        // Random phases across the policies and quantum settings.
        for (int ph = 0; ph < 11; ph++) begin
            if (ph == 4) begin
                snd_idle = 70;
                rcv_idle = 33;
            end else if (ph == 8) begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            cfg_write(REG_POLICY, {5'd0, pols[ph]});
            cfg_write(REG_QUANTUM, qnts[ph]);
            for (int i = 0; i < 135; i++) begin
                if ($urandom_range(9) == 0)
                    add_load(ID_W'($urandom), ARR_W'($urandom),
                             BURST_W'($urandom), PRIO_W'($urandom));
                else
                    add_tick();
            end
            drain();
        end

        if (n_err == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
